// File: rtl/ffra_pkg.sv
// shared types and constants of the first-fit range allocator
`timescale 1ns / 1ps
`default_nettype none
package ffra_pkg;

    // field widths
    localparam int PAGES_W  = 21;   // request page count
    localparam int RPAGES_W = 22;   // reserved page count, guard page included
    localparam int START_W  = 23;   // start page, wide enough for the smallest page size
    localparam int CAND_W   = 25;   // candidate page and page sums
    localparam int IDX_W    = 11;   // table index and fill level

    // opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // register indexes
    localparam logic REG_AREA_BASE = 1'b0;
    localparam logic REG_MAX_REQ   = 1'b1;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE   = 3'd1;
    localparam logic [2:0] ST_FULL       = 3'd2;
    localparam logic [2:0] ST_EXHAUSTED  = 3'd3;
    localparam logic [2:0] ST_NULL       = 3'd4;
    localparam logic [2:0] ST_MISALIGNED = 3'd5;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd6;

    typedef struct packed {
        logic [START_W-1:0]  start;
        logic [RPAGES_W-1:0] rpages;
    } entry_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic               mode_free;
        logic               commit;
        logic [IDX_W-1:0]   count;
        logic [IDX_W-1:0]   pos;
        logic [PAGES_W-1:0] pages;
        logic [31:0]        addr;
        entry_t             new_entry;
    } ctl_t;

    // report of one cell back to the controller
    typedef struct packed {
        logic              stop;
        logic              at_end;
        logic [CAND_W-1:0] cand;
    } rep_t;

endpackage
`default_nettype wire

// File: rtl/ffra_cell.sv
// one table slot with its share of the first-fit walk
`timescale 1ns / 1ps
`default_nettype none
module ffra_cell
    import ffra_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int ADDR_SHIFT = 12
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ctl_t              ctl,
    input  wire logic              tok_in,
    input  wire logic [CAND_W-1:0] cand_in,
    input  wire entry_t            left_entry,
    input  wire entry_t            right_entry,
    output logic                   tok_out,
    output logic [CAND_W-1:0]      cand_out,
    output entry_t                 entry,
    output rep_t                   rep
);

    logic              tok_reg;
    logic [CAND_W-1:0] cand_reg;
    entry_t            entry_reg;
    entry_t            entry_next;
    logic              end_hit;
    logic              match;
    logic              fit;
    logic              stop;

    // token position of the walk
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_in;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg  <= cand_in;
        entry_reg <= entry_next;
    end

    // stop tests at the token
    always_comb
    begin
        end_hit = IDX_W'(IDX) >= ctl.count;
        match   = (40'(entry_reg.start) << ADDR_SHIFT) == 40'(ctl.addr);
        fit     = (CAND_W'(ctl.pages) + cand_reg) < CAND_W'(entry_reg.start);
        stop    = tok_reg && (end_hit || (ctl.mode_free ? match : fit));
    end

    assign tok_out    = tok_reg && !stop;
    assign cand_out   = CAND_W'(entry_reg.start) + CAND_W'(entry_reg.rpages);
    assign rep.stop   = stop;
    assign rep.at_end = tok_reg && end_hit;
    assign rep.cand   = stop ? cand_reg : '0;
    assign entry      = entry_reg;

    // insert shifts up, remove shifts down
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.commit)
        begin
            if (ctl.mode_free)
            begin
                if (IDX_W'(IDX) >= ctl.pos)
                begin
                    entry_next = right_entry;
                end
            end
            else
            begin
                if (IDX_W'(IDX) > ctl.pos)
                begin
                    entry_next = left_entry;
                end
                else if (IDX_W'(IDX) == ctl.pos)
                begin
                    entry_next = ctl.new_entry;
                end
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/ffra_ctrl.sv
// sequencer, configuration registers and result register of the allocator
`timescale 1ns / 1ps
`default_nettype none
module ffra_ctrl
    import ffra_pkg::*;
#(
    parameter int MAX_RANGES = 64,
    parameter int PAGE_BYTES = 4096
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              opcode,
    input  wire logic [31:0]       request_bytes,
    input  wire logic [31:0]       release_address,
    input  wire logic              cfg_write,
    input  wire logic              cfg_index,
    input  wire logic [20:0]       cfg_data,
    input  wire rep_t              rep,
    input  wire logic              fell_off,
    output logic                   busy,
    output logic                   launch,
    output logic [CAND_W-1:0]      launch_cand,
    output ctl_t                   ctl,
    output logic                   done,
    output logic [2:0]             status,
    output logic [31:0]            granted_address
);

    localparam int PL    = $clog2(PAGE_BYTES);
    localparam int CNT_W = $clog2(MAX_RANGES + 1);
    localparam int KW    = $clog2(MAX_RANGES);
    localparam logic [CAND_W-1:0] SPACE_PAGES = CAND_W'(64'(1) << (32 - PL));

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_WALK   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [19:0]        base_reg;
    logic [20:0]        max_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [KW-1:0]      k_reg, k_next;
    logic [KW-1:0]      pos_reg, pos_next;
    logic               free_reg, free_next;
    logic [PAGES_W-1:0] pages_reg, pages_next;
    logic [31:0]        addr_reg, addr_next;
    logic [CAND_W-1:0]  cand_reg, cand_next;
    logic               done_reg, done_next;
    logic [2:0]         status_reg, status_next;
    logic [31:0]        grant_reg, grant_next;

    logic               accept;
    logic [32:0]        round_sum;
    logic [32:0]        req_pages;
    logic               bad_size;
    logic [CAND_W-1:0]  end_page;

    assign accept    = start && (state_reg == S_IDLE);
    assign round_sum = {1'b0, request_bytes} + 33'(PAGE_BYTES - 1);
    assign req_pages = round_sum >> PL;
    assign bad_size  = (req_pages == '0) || (req_pages > 33'(max_reg));
    assign end_page  = rep.cand + CAND_W'(pages_reg) + CAND_W'(1);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= 20'd2048;
            max_reg  <= 21'd4096;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_AREA_BASE: base_reg <= cfg_data[19:0];
                REG_MAX_REQ:   max_reg  <= cfg_data;
                default:       ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        pos_reg    <= pos_next;
        free_reg   <= free_next;
        pages_reg  <= pages_next;
        addr_reg   <= addr_next;
        cand_reg   <= cand_next;
        status_reg <= status_next;
        grant_reg  <= grant_next;
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        k_next      = k_reg;
        pos_next    = pos_reg;
        free_next   = free_reg;
        pages_next  = pages_reg;
        addr_next   = addr_reg;
        cand_next   = cand_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        grant_next  = grant_reg;
        launch      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    free_next  = opcode;
                    addr_next  = release_address;
                    pages_next = req_pages[PAGES_W-1:0];
                    k_next     = '0;
                    grant_next = '0;
                    if (opcode == OP_ALLOC)
                    begin
                        if (bad_size)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_BAD_SIZE;
                        end
                        else if (count_reg == CNT_W'(MAX_RANGES))
                        begin
                            done_next   = 1'b1;
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            launch     = 1'b1;
                            state_next = S_WALK;
                        end
                    end
                    else
                    begin
                        if (release_address == '0)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_NULL;
                        end
                        else if (release_address[PL-1:0] != '0)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_MISALIGNED;
                        end
                        else
                        begin
                            launch     = 1'b1;
                            state_next = S_WALK;
                        end
                    end
                end
            end
            S_WALK:
            begin
                k_next = k_reg + KW'(1);
                if (rep.stop)
                begin
                    pos_next = k_reg;
                    if (free_reg)
                    begin
                        if (rep.at_end)
                        begin
                            done_next   = 1'b1;
                            status_next = ST_NOT_FOUND;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_COMMIT;
                        end
                    end
                    else if (end_page > SPACE_PAGES)
                    begin
                        done_next   = 1'b1;
                        status_next = ST_EXHAUSTED;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        cand_next  = rep.cand;
                        grant_next = 32'(rep.cand) << PL;
                        state_next = S_COMMIT;
                    end
                end
                else if (fell_off)
                begin
                    done_next   = 1'b1;
                    status_next = ST_NOT_FOUND;
                    state_next  = S_IDLE;
                end
            end
            S_COMMIT:
            begin
                done_next   = 1'b1;
                status_next = ST_OK;
                state_next  = S_IDLE;
                if (free_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // broadcast to the cells
    always_comb
    begin
        ctl.mode_free        = free_reg;
        ctl.commit           = (state_reg == S_COMMIT);
        ctl.count            = IDX_W'(count_reg);
        ctl.pos              = IDX_W'(pos_reg);
        ctl.pages            = pages_reg;
        ctl.addr             = addr_reg;
        ctl.new_entry.start  = START_W'(cand_reg);
        ctl.new_entry.rpages = RPAGES_W'(pages_reg) + RPAGES_W'(1);
    end

    assign launch_cand     = CAND_W'(base_reg);
    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign status          = status_reg;
    assign granted_address = grant_reg;

endmodule
`default_nettype wire

// File: rtl/first_fit_range_allocator.sv
// top level of the first-fit address range allocator
//
// Command port: a transaction is taken at a clock edge with start high and
// busy low. opcode 0 allocates request_bytes (rounded up to pages), opcode 1
// frees the range that starts at release_address. Exactly one result per
// transaction appears on status / granted_address for one cycle, marked by
// done; the receiver cannot stall it.
// A request rejected by its size, a full table, a null or a misaligned
// address answers straight from the idle state. Otherwise a token walks
// the row of table cells one cell per cycle; a walk that stops at a cell
// and updates the table goes through the commit state before the result,
// one that ends in space exhausted or not found answers from the walk. One
// transaction at a time; busy stays high until the result is shown.
// Configuration: cfg_write with cfg_index 0 sets area_base_page, index 1 sets
// max_request_pages; write only while busy is low.
// Reset empties the table at once and loads area_base_page 2048 and
// max_request_pages 4096.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_range_allocator
    import ffra_pkg::*;
#(
    parameter int MAX_RANGES = 64,
    parameter int PAGE_BYTES = 4096
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        opcode,
    input  wire logic [31:0] request_bytes,
    input  wire logic [31:0] release_address,
    output logic             done,
    output logic [2:0]       status,
    output logic [31:0]      granted_address,
    input  wire logic        cfg_write,
    input  wire logic        cfg_index,
    input  wire logic [20:0] cfg_data
);

    localparam int PL = $clog2(PAGE_BYTES);

    ctl_t              ctl;
    rep_t              rep;
    rep_t              cell_rep [MAX_RANGES];
    entry_t            entries  [MAX_RANGES];
    logic              tok      [MAX_RANGES+1];
    logic [CAND_W-1:0] cand     [MAX_RANGES+1];
    logic              launch;
    logic [CAND_W-1:0] launch_cand;

    assign tok[0]  = launch;
    assign cand[0] = launch_cand;

    // row of table cells
    for (genvar i = 0; i < MAX_RANGES; i++)
    begin : g_cell
        ffra_cell #(
            .IDX        (i),
            .ADDR_SHIFT (PL)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .tok_in      (tok[i]),
            .cand_in     (cand[i]),
            .left_entry  (entries[(i == 0) ? 0 : i - 1]),
            .right_entry (entries[(i == MAX_RANGES - 1) ? i : i + 1]),
            .tok_out     (tok[i+1]),
            .cand_out    (cand[i+1]),
            .entry       (entries[i]),
            .rep         (cell_rep[i])
        );
    end

    // only the cell that holds the token reports
    always_comb
    begin
        rep = '0;
        for (int i = 0; i < MAX_RANGES; i++)
        begin
            rep = rep | cell_rep[i];
        end
    end

    ffra_ctrl #(
        .MAX_RANGES (MAX_RANGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .opcode          (opcode),
        .request_bytes   (request_bytes),
        .release_address (release_address),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .rep             (rep),
        .fell_off        (tok[MAX_RANGES]),
        .busy            (busy),
        .launch          (launch),
        .launch_cand     (launch_cand),
        .ctl             (ctl),
        .done            (done),
        .status          (status),
        .granted_address (granted_address)
    );

endmodule
`default_nettype wire

// File: rtl/ffra_checker.sv
// port checker of the allocator and its bind
`timescale 1ns / 1ps
`default_nettype none
module ffra_checker
    import ffra_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [2:0]  status,
    input wire logic [31:0] granted_address
);

    // an accepted transaction either answers at once or keeps the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("transaction accepted but neither busy nor done");

    // a result is shown only once the block is idle again
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // a failed request grants no address
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> (granted_address == '0))
        else $error("address granted on a failed request");

    // status codes stay within the defined set
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status <= ST_NOT_FOUND))
        else $error("undefined status code");

    // busy only ends with a result
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

endmodule

bind first_fit_range_allocator ffra_checker u_ffra_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .status          (status),
    .granted_address (granted_address)
);
`default_nettype wire
